// ===== hdl/cpcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_pkg
// Shared types, constants and helpers of the circle pair collision resolver.
// ----------------------------------------------------------------------------
package cpcr_pkg;

  // Ball store geometry
  localparam int MAX_BALLS = 32;
  localparam int BALL_AW   = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
  localparam int CNT_W     = $clog2(MAX_BALLS + 1);
  localparam int IDX_W     = 5;

  // Arithmetic constants
  localparam logic [15:0] RESTITUTION_RST = 16'd13107;
  localparam logic [31:0] DIST_FLOOR      = 32'd7;
  localparam logic [16:0] ONE_Q16         = 17'h10000;
  localparam int          STEP_W          = 5;
  localparam int          SQRT_STEPS      = 32;
  localparam int          DIV_STEPS       = 31;

  // Stream widths
  localparam int S_TDATA_W = 160;
  localparam int M_TDATA_W = 136;

  // Input item kinds
  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_RESOLVE = 2'd2
  } cmd_e;

  // One stored ball, px in the lowest bits
  typedef struct packed {
    logic [30:0] r;
    logic [31:0] vy;
    logic [31:0] vx;
    logic [31:0] py;
    logic [31:0] px;
  } ball_t;

  localparam int BALL_W = $bits(ball_t);

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD_A,
    OP_LOAD_B,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_RSQ,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV,
    OP_NORM,
    OP_CX,
    OP_CY,
    OP_POS,
    OP_T1,
    OP_T2,
    OP_MAG,
    OP_MAGR,
    OP_IX,
    OP_IY,
    OP_VEL,
    OP_EMIT
  } dp_op_e;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_A,
    ST_LD_A,
    ST_RD_B,
    ST_LD_B,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_RSQ,
    ST_CMP,
    ST_SQRT,
    ST_DIVI,
    ST_DIV,
    ST_NORM,
    ST_CX,
    ST_CY,
    ST_POS,
    ST_T1,
    ST_T2,
    ST_MAG,
    ST_MAGR,
    ST_IX,
    ST_IY,
    ST_VEL,
    ST_WR_B,
    ST_WR_A,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    dp_op_e             op;
    logic               wr_a;
    logic               wr_b;
    logic               wr_src_in;
    logic [BALL_AW-1:0] addr_a;
    logic [BALL_AW-1:0] addr_b;
    logic               out_body;
    logic [BALL_AW-1:0] out_idx;
    logic               out_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic far;
    logic no_ovl;
    logic sep;
  } dp_status_t;

  // Clamp to the signed 32 bit range
  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] res;
    if (v > 37'sh0_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -37'sh0_8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Magnitude with a sign attached
  function automatic logic signed [35:0] sgn36(input logic [34:0] m, input logic neg);
    logic signed [35:0] s;
    s = $signed({1'b0, m});
    return neg ? -s : s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/circle_pair_collision_resolver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_pair_collision_resolver
// Collects the circles of two bodies and resolves every A-B pair by position
// correction and restitution impulse, then streams out all updated balls.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: command; tdata: pos_x, pos_y, vel_x, vel_y, radius
//  m_axis    out        tuser: body_id; tdata: ball_index, pos/vel; tlast: last
//  cfg       in         restitution, Q0.16
//
//  A load is written into the ball store as it is accepted; loads may come back to back.
//  A resolve walks every A-B pair: a pair that is not touching leaves after the overlap
//  test, an overlapping one runs a 32-step square root, a 31-step divider and the
//  shared 34x34 multiplier, and each A ball is fetched before and written back after its pairs.
//  Each result then passes through read, load and output states and waits out any output stall; input waits meanwhile.
//  Reset clears both ball counts; ball store contents are not cleared.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolver (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [159:0] s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y, radius, pad
  input  wire logic [1:0]   s_axis_tuser,  // command
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [135:0]      m_axis_tdata,  // ball_index, pos_x, pos_y, vel_x, vel_y, pad
  output logic              m_axis_tuser,  // body_id
  output logic              m_axis_tlast
);
  import cpcr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  cpcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cpcr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata),
    .out_body_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== hdl/cpcr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/cpcr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_datapath
// Ball stores, working registers, shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
module cpcr_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [15:0]                   cfg_wdata_i,
  input  wire logic [cpcr_pkg::S_TDATA_W-1:0] in_data_i,
  input  wire cpcr_pkg::dp_cmd_t             cmd_i,
  output cpcr_pkg::dp_status_t               status_o,
  output logic [cpcr_pkg::M_TDATA_W-1:0]     out_data_o,
  output logic                               out_body_o,
  output logic                               out_last_o
);
  import cpcr_pkg::*;

  logic [15:0] rest_q;

  ball_t in_ball, rd_a, rd_b, wd_a, wd_b;
  ball_t a_q, b_q;

  logic [31:0]        ax_q, ay_q, rsum_q;
  logic               dxn_q, dyn_q;
  logic [67:0]        mul_q;
  logic [33:0]        mul_a_c, mul_b_c;
  logic [63:0]        sx2_q;
  logic [64:0]        d2_q;
  logic [63:0]        sq_v_q, sq_res_q, sq_bit_q, sq_t;
  logic [31:0]        dist_q, dist_c;
  logic signed [33:0] pen_q;
  logic [33:0]        pen_mag;
  logic [31:0]        remx_q, remy_q;
  logic [30:0]        nlx_q, nly_q, qx_q, qy_q;
  logic [32:0]        tx, ty;
  logic signed [35:0] cx_q, cy_q, t1_q, van_q, ix_q, iy_q, t2_c;
  logic [33:0]        mag_q, van_mag;
  logic signed [32:0] dx_c, dy_c, dvx_c, dvy_c;
  logic [32:0]        dvx_mag, dvy_mag;
  logic [IDX_W-1:0]   out_idx_q;
  ball_t              out_ball_q;

  assign in_ball = ball_t'(in_data_i[BALL_W-1:0]);
  assign wd_a    = cmd_i.wr_src_in ? in_ball : a_q;
  assign wd_b    = cmd_i.wr_src_in ? in_ball : b_q;

  // Ball stores of body A and body B
  cpcr_ram #(.Width(BALL_W), .Depth(MAX_BALLS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (cmd_i.addr_a),
    .wdata_i (wd_a),
    .raddr_i (cmd_i.addr_a),
    .rdata_o (rd_a)
  );

  cpcr_ram #(.Width(BALL_W), .Depth(MAX_BALLS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (cmd_i.addr_b),
    .wdata_i (wd_b),
    .raddr_i (cmd_i.addr_b),
    .rdata_o (rd_b)
  );

  // Restitution register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= RESTITUTION_RST;
    end else if (cfg_we_i) begin
      rest_q <= cfg_wdata_i;
    end
  end

  // Offsets, magnitudes and helper terms
  always_comb begin
    dx_c    = $signed({b_q.px[31], b_q.px}) - $signed({a_q.px[31], a_q.px});
    dy_c    = $signed({b_q.py[31], b_q.py}) - $signed({a_q.py[31], a_q.py});
    dvx_c   = $signed({b_q.vx[31], b_q.vx}) - $signed({a_q.vx[31], a_q.vx});
    dvy_c   = $signed({b_q.vy[31], b_q.vy}) - $signed({a_q.vy[31], a_q.vy});
    dvx_mag = dvx_c[32] ? 33'(-dvx_c) : 33'(dvx_c);
    dvy_mag = dvy_c[32] ? 33'(-dvy_c) : 33'(dvy_c);
    pen_mag = pen_q[33] ? 34'(-pen_q) : 34'(pen_q);
    van_mag = van_q[35] ? 34'(-van_q) : van_q[33:0];
    sq_t    = sq_res_q + sq_bit_q;
    dist_c  = (sq_res_q[31:0] < DIST_FLOOR) ? DIST_FLOOR : sq_res_q[31:0];
    tx      = {remx_q, nlx_q[30]};
    ty      = {remy_q, nly_q[30]};
    t2_c    = sgn36({1'b0, mul_q[63:30]}, dvy_c[32] ^ dyn_q);
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a_c = '0;
    mul_b_c = '0;
    case (cmd_i.op)
      OP_SQX:  begin mul_a_c = 34'(ax_q);    mul_b_c = 34'(ax_q);   end
      OP_SQY:  begin mul_a_c = 34'(ay_q);    mul_b_c = 34'(ay_q);   end
      OP_RSQ:  begin mul_a_c = 34'(rsum_q);  mul_b_c = 34'(rsum_q); end
      OP_NORM: begin mul_a_c = 34'(qx_q);    mul_b_c = pen_mag;     end
      OP_CX:   begin mul_a_c = 34'(qy_q);    mul_b_c = pen_mag;     end
      OP_POS:  begin mul_a_c = 34'(dvx_mag); mul_b_c = 34'(qx_q);   end
      OP_T1:   begin mul_a_c = 34'(dvy_mag); mul_b_c = 34'(qy_q);   end
      OP_MAG:  begin mul_a_c = van_mag;      mul_b_c = 34'(ONE_Q16 + 17'(rest_q)); end
      OP_MAGR: begin mul_a_c = 34'(qx_q);    mul_b_c = mul_q[50:17]; end
      OP_IX:   begin mul_a_c = 34'(qy_q);    mul_b_c = mag_q;       end
      default: begin mul_a_c = '0;           mul_b_c = '0;          end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a_c * mul_b_c;
  end

  // Per-step work
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD_A: a_q <= rd_a;
      OP_LOAD_B: b_q <= rd_b;
      OP_DIFF: begin
        dxn_q  <= dx_c[32];
        dyn_q  <= dy_c[32];
        ax_q   <= dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
        ay_q   <= dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
        rsum_q <= 32'({1'b0, a_q.r} + {1'b0, b_q.r});
      end
      OP_SQY: sx2_q <= mul_q[63:0];
      OP_RSQ: d2_q  <= {1'b0, sx2_q} + {1'b0, mul_q[63:0]};
      OP_SQRT_INIT: begin
        sq_v_q   <= d2_q[63:0];
        sq_res_q <= '0;
        sq_bit_q <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT: begin
        if (sq_v_q >= sq_t) begin
          sq_v_q   <= sq_v_q - sq_t;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OP_DIV_INIT: begin
        // quotient fits 31 bits, so the upper partial remainder starts below dist
        dist_q <= dist_c;
        pen_q  <= $signed({2'b00, rsum_q}) - $signed({2'b00, dist_c});
        remx_q <= {1'b0, ax_q[31:1]};
        remy_q <= {1'b0, ay_q[31:1]};
        nlx_q  <= {ax_q[0], 30'd0};
        nly_q  <= {ay_q[0], 30'd0};
        qx_q   <= '0;
        qy_q   <= '0;
      end
      OP_DIV: begin
        if (tx >= {1'b0, dist_q}) begin
          remx_q <= 32'(tx - {1'b0, dist_q});
          qx_q   <= {qx_q[29:0], 1'b1};
        end else begin
          remx_q <= tx[31:0];
          qx_q   <= {qx_q[29:0], 1'b0};
        end
        if (ty >= {1'b0, dist_q}) begin
          remy_q <= 32'(ty - {1'b0, dist_q});
          qy_q   <= {qy_q[29:0], 1'b1};
        end else begin
          remy_q <= ty[31:0];
          qy_q   <= {qy_q[29:0], 1'b0};
        end
        nlx_q <= nlx_q << 1;
        nly_q <= nly_q << 1;
      end
      OP_CX: cx_q <= sgn36({3'b0, mul_q[62:31]}, dxn_q ^ pen_q[33]);
      OP_CY: cy_q <= sgn36({3'b0, mul_q[62:31]}, dyn_q ^ pen_q[33]);
      OP_POS: begin
        a_q.px <= sat32(37'($signed(a_q.px)) - 37'(cx_q));
        a_q.py <= sat32(37'($signed(a_q.py)) - 37'(cy_q));
        b_q.px <= sat32(37'($signed(b_q.px)) + 37'(cx_q));
        b_q.py <= sat32(37'($signed(b_q.py)) + 37'(cy_q));
      end
      OP_T1: t1_q  <= sgn36({1'b0, mul_q[63:30]}, dvx_c[32] ^ dxn_q);
      OP_T2: van_q <= t1_q + t2_c;
      OP_MAGR: mag_q <= mul_q[50:17];
      OP_IX: ix_q <= sgn36({1'b0, mul_q[63:30]}, dxn_q);
      OP_IY: iy_q <= sgn36({1'b0, mul_q[63:30]}, dyn_q);
      OP_VEL: begin
        a_q.vx <= sat32(37'($signed(a_q.vx)) - 37'(ix_q));
        a_q.vy <= sat32(37'($signed(a_q.vy)) - 37'(iy_q));
        b_q.vx <= sat32(37'($signed(b_q.vx)) + 37'(ix_q));
        b_q.vy <= sat32(37'($signed(b_q.vy)) + 37'(iy_q));
      end
      OP_EMIT: begin
        out_ball_q <= cmd_i.out_body ? rd_b : rd_a;
        out_idx_q  <= IDX_W'(cmd_i.out_idx);
        out_body_o <= cmd_i.out_body;
        out_last_o <= cmd_i.out_last;
      end
      default: ;
    endcase
  end

  // Status for the controller
  assign status_o.far    = (ax_q >= rsum_q) || (ay_q >= rsum_q);
  assign status_o.no_ovl = d2_q >= {1'b0, mul_q[63:0]};
  assign status_o.sep    = !van_q[35] && (van_q != '0);

  assign out_data_o = {3'b000, out_ball_q.vy, out_ball_q.vx, out_ball_q.py,
                       out_ball_q.px, out_idx_q};

endmodule
`default_nettype wire

// ===== hdl/cpcr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_ctrl
// Sequencer: loads, pair walk with per-pair micro-steps, and result output.
// ----------------------------------------------------------------------------
module cpcr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           in_cmd_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire cpcr_pkg::dp_status_t status_i,
  output cpcr_pkg::dp_cmd_t         cmd_o
);
  import cpcr_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [BALL_AW-1:0] i_q, i_d, j_q, j_d, em_idx_q, em_idx_d;
  logic               em_body_q, em_body_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               valid_q, valid_d;
  logic               a_end, b_end, em_last;

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      a_cnt_q   <= '0;
      b_cnt_q   <= '0;
      i_q       <= '0;
      j_q       <= '0;
      em_idx_q  <= '0;
      em_body_q <= 1'b0;
      step_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      a_cnt_q   <= a_cnt_d;
      b_cnt_q   <= b_cnt_d;
      i_q       <= i_d;
      j_q       <= j_d;
      em_idx_q  <= em_idx_d;
      em_body_q <= em_body_d;
      step_q    <= step_d;
      valid_q   <= valid_d;
    end
  end

  assign a_end   = (CNT_W'(i_q) + CNT_W'(1)) == a_cnt_q;
  assign b_end   = (CNT_W'(j_q) + CNT_W'(1)) == b_cnt_q;
  assign em_last = em_body_q ? ((CNT_W'(em_idx_q) + CNT_W'(1)) == b_cnt_q)
                             : (((CNT_W'(em_idx_q) + CNT_W'(1)) == a_cnt_q) &&
                                (b_cnt_q == '0));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    a_cnt_d   = a_cnt_q;
    b_cnt_d   = b_cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    em_idx_d  = em_idx_q;
    em_body_d = em_body_q;
    step_d    = step_q;
    valid_d   = valid_q;

    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    cmd_o.addr_a    = i_q;
    cmd_o.addr_b    = j_q;
    cmd_o.out_body  = em_body_q;
    cmd_o.out_idx   = em_idx_q;
    cmd_o.out_last  = em_last;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_LOAD_A: begin
              if (a_cnt_q < CNT_W'(MAX_BALLS)) begin
                cmd_o.wr_a      = 1'b1;
                cmd_o.wr_src_in = 1'b1;
                cmd_o.addr_a    = a_cnt_q[BALL_AW-1:0];
                a_cnt_d         = a_cnt_q + CNT_W'(1);
              end
            end
            CMD_LOAD_B: begin
              if (b_cnt_q < CNT_W'(MAX_BALLS)) begin
                cmd_o.wr_b      = 1'b1;
                cmd_o.wr_src_in = 1'b1;
                cmd_o.addr_b    = b_cnt_q[BALL_AW-1:0];
                b_cnt_d         = b_cnt_q + CNT_W'(1);
              end
            end
            CMD_RESOLVE: begin
              i_d       = '0;
              j_d       = '0;
              em_idx_d  = '0;
              em_body_d = (a_cnt_q == '0);
              if (a_cnt_q == '0 && b_cnt_q == '0) begin
                state_d = ST_IDLE;
              end else if (a_cnt_q == '0 || b_cnt_q == '0) begin
                state_d = ST_EM_RD;
              end else begin
                state_d = ST_RD_A;
              end
            end
            default: ;
          endcase
        end
      end
      // Fetch working balls
      ST_RD_A: state_d = ST_LD_A;
      ST_LD_A: begin cmd_o.op = OP_LOAD_A; state_d = ST_RD_B; end
      ST_RD_B: state_d = ST_LD_B;
      ST_LD_B: begin cmd_o.op = OP_LOAD_B; state_d = ST_DIFF; end
      // Overlap test
      ST_DIFF: begin cmd_o.op = OP_DIFF; state_d = ST_SQX; end
      ST_SQX: begin
        cmd_o.op = OP_SQX;
        state_d  = status_i.far ? ST_WR_B : ST_SQY;
      end
      ST_SQY: begin cmd_o.op = OP_SQY; state_d = ST_RSQ; end
      ST_RSQ: begin cmd_o.op = OP_RSQ; state_d = ST_CMP; end
      ST_CMP: begin
        cmd_o.op = OP_SQRT_INIT;
        step_d   = '0;
        state_d  = status_i.no_ovl ? ST_WR_B : ST_SQRT;
      end
      // Distance, one result bit per cycle
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          state_d = ST_DIVI;
        end
      end
      // Normal, one quotient bit per cycle for both axes
      ST_DIVI: begin cmd_o.op = OP_DIV_INIT; step_d = '0; state_d = ST_DIV; end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_NORM;
        end
      end
      // Position correction
      ST_NORM: begin cmd_o.op = OP_NORM; state_d = ST_CX;  end
      ST_CX:   begin cmd_o.op = OP_CX;   state_d = ST_CY;  end
      ST_CY:   begin cmd_o.op = OP_CY;   state_d = ST_POS; end
      ST_POS:  begin cmd_o.op = OP_POS;  state_d = ST_T1;  end
      // Impulse
      ST_T1:   begin cmd_o.op = OP_T1;   state_d = ST_T2;  end
      ST_T2:   begin cmd_o.op = OP_T2;   state_d = ST_MAG; end
      ST_MAG: begin
        cmd_o.op = OP_MAG;
        state_d  = status_i.sep ? ST_WR_B : ST_MAGR;
      end
      ST_MAGR: begin cmd_o.op = OP_MAGR; state_d = ST_IX;  end
      ST_IX:   begin cmd_o.op = OP_IX;   state_d = ST_IY;  end
      ST_IY:   begin cmd_o.op = OP_IY;   state_d = ST_VEL; end
      ST_VEL:  begin cmd_o.op = OP_VEL;  state_d = ST_WR_B; end
      // Write back and advance the pair walk
      ST_WR_B: begin
        cmd_o.wr_b = 1'b1;
        if (b_end) begin
          j_d     = '0;
          state_d = ST_WR_A;
        end else begin
          j_d     = j_q + BALL_AW'(1);
          state_d = ST_RD_B;
        end
      end
      ST_WR_A: begin
        cmd_o.wr_a = 1'b1;
        if (a_end) begin
          state_d = ST_EM_RD;
        end else begin
          i_d     = i_q + BALL_AW'(1);
          state_d = ST_RD_A;
        end
      end
      // Result output
      ST_EM_RD: begin
        cmd_o.addr_a = em_idx_q;
        cmd_o.addr_b = em_idx_q;
        state_d      = ST_EM_LD;
      end
      ST_EM_LD: begin
        cmd_o.op = OP_EMIT;
        valid_d  = 1'b1;
        state_d  = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (out_ready_i) begin
          valid_d = 1'b0;
          if (em_last) begin
            a_cnt_d = '0;
            b_cnt_d = '0;
            state_d = ST_IDLE;
          end else begin
            if (!em_body_q && ((CNT_W'(em_idx_q) + CNT_W'(1)) == a_cnt_q)) begin
              em_body_d = 1'b1;
              em_idx_d  = '0;
            end else begin
              em_idx_d  = em_idx_q + BALL_AW'(1);
            end
            state_d = ST_EM_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
